// ----- rtl/mecr_pkg.sv -----
// Package for the minimum-eigenvalue corner response core.
// Shared sizes, register indexes, and the command and status structs.
// No dependencies.
`default_nettype none

package mecr_pkg;

  // Frame limits and the pixel ring
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int RING_DEPTH = 4 * MAX_WIDTH + 8;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int PEND_W     = $clog2(2 * MAX_WIDTH + 4);

  // Field and register widths
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int COORD_W    = 10;
  localparam int RESP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Window geometry: Sobel kernel and the pixel grid it needs
  localparam int SOBEL   = 3;
  localparam int WIN     = SOBEL + 2;
  localparam int GRID    = WIN * WIN;
  localparam int NGRAD   = SOBEL * SOBEL;
  localparam int FIDX_W  = $clog2(WIN);
  localparam int GK_W    = $clog2(NGRAD);

  // Arithmetic widths
  localparam int GRAD_W     = 11;
  localparam int ACC_W      = 25;
  localparam int PROD_W     = 2 * ACC_W;
  localparam int DISC_W     = 50;
  localparam int ROOT_W     = DISC_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQ_W       = $clog2(ROOT_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [RESP_W-1:0] THRESH_RESET = 24'd5;

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Multiplier operation; the product lands in the matching accumulator or the discriminant
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_XX,
    MUL_YY,
    MUL_XY,
    MUL_DD,
    MUL_SS
  } mul_op_t;

  typedef struct packed {
    logic              accept;
    logic              rd_en;
    logic [FIDX_W-1:0] fetch_row;
    logic [FIDX_W-1:0] fetch_col;
    logic              grad_load;
    logic              grad_shift;
    mul_op_t           mul_op;
    logic              clear;
    logic              sqrt_step;
    logic              fin;
    logic              load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic fire;
    logic border;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/min_eigen_corner_response_core.sv -----
// Top level of the minimum-eigenvalue corner response core.
// Instantiates mecr_ctrl, mecr_dp and mecr_ram; depends on mecr_pkg.
//
//   Channel   Signals                                   Direction
//   input     in_valid, in_stall, command, pixel        item in
//   output    out_valid, out_stall, response, column,   result out
//             row, last_of_frame
//   config    cfg_write, cfg_index, cfg_data            register write
//
// A pixel that yields no result, and a flush with nothing pending, are simply accepted.
// A border position goes straight to the result. An inner position takes 25 reads
// from the single read port of the pixel ring, 29 products on the one multiplier,
// and the one-bit-per-cycle square root.
// Synchronous active-high reset; the pixel ring needs no clearing.
// The next item is taken while a result waits in the output register.
`default_nettype none

module min_eigen_corner_response_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic [mecr_pkg::PIX_W-1:0]       pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mecr_pkg::RESP_W-1:0]      response,
  output logic [mecr_pkg::COORD_W-1:0]     column,
  output logic [mecr_pkg::COORD_W-1:0]     row,
  output logic                             last_of_frame,
  input  logic                             cfg_write,
  input  logic [mecr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mecr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mecr_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic               ram_wr_en, ram_rd_en;
  logic [SLOT_W-1:0]  ram_wr_addr, ram_rd_addr;
  logic [PIX_W-1:0]   ram_wr_data, ram_rd_data;

  mecr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  mecr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .pixel         (pixel),
    .cmd           (cmd),
    .sts           (sts),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .response      (response),
    .column        (column),
    .row           (row),
    .last_of_frame (last_of_frame)
  );

  // Pixel ring
  mecr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

// ----- rtl/mecr_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module mecr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4104,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mecr_dp.sv -----
// Datapath: frame bookkeeping, ring addressing, window grid, gradients,
// shared multiplier, accumulators, bit-serial square root and result register.
// Depends on mecr_pkg.
`default_nettype none

module mecr_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mecr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mecr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              command,
  input  logic [mecr_pkg::PIX_W-1:0]        pixel,
  input  mecr_pkg::dp_cmd_t                 cmd,
  output mecr_pkg::dp_sts_t                 sts,
  output logic                              ram_wr_en,
  output logic [mecr_pkg::SLOT_W-1:0]       ram_wr_addr,
  output logic [mecr_pkg::PIX_W-1:0]        ram_wr_data,
  output logic                              ram_rd_en,
  output logic [mecr_pkg::SLOT_W-1:0]       ram_rd_addr,
  input  logic [mecr_pkg::PIX_W-1:0]        ram_rd_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [mecr_pkg::RESP_W-1:0]       response,
  output logic [mecr_pkg::COORD_W-1:0]      column,
  output logic [mecr_pkg::COORD_W-1:0]      row,
  output logic                              last_of_frame
);
  import mecr_pkg::*;

  localparam int OFF_W = SLOT_W + 1;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (r < SIZE_W'(3)) r = SIZE_W'(3);
    if (r > hi) r = hi;
    return r;
  endfunction

  // Sobel difference: (p0-n0) + 2*(p1-n1) + (p2-n2)
  function automatic logic signed [GRAD_W-1:0] sobel_d(
      input logic [PIX_W-1:0] p0, input logic [PIX_W-1:0] n0,
      input logic [PIX_W-1:0] p1, input logic [PIX_W-1:0] n1,
      input logic [PIX_W-1:0] p2, input logic [PIX_W-1:0] n2);
    logic [GRAD_W-1:0] s;
    s = GRAD_W'(p0) - GRAD_W'(n0) + ((GRAD_W'(p1) - GRAD_W'(n1)) << 1)
      + GRAD_W'(p2) - GRAD_W'(n2);
    return signed'(s);
  endfunction

  // Configuration and frame bookkeeping
  logic [SIZE_W-1:0]  width_q, height_q;
  logic [RESP_W-1:0]  thresh_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [PEND_W-1:0]  pend_q;
  logic [COORD_W-1:0] ocol_q, orow_q;

  logic [SIZE_W-1:0]  wm1, hm1;
  logic [PEND_W-1:0]  lim, pend_inc;
  logic [SLOT_W-1:0]  slot_inc, base_sl, base_pn, base;
  logic               is_pix, fire, border;

  assign wm1      = width_q - 1'b1;
  assign hm1      = height_q - 1'b1;
  assign lim      = PEND_W'({width_q, 1'b0}) + PEND_W'(2);
  assign pend_inc = pend_q + 1'b1;
  assign is_pix   = (command == CMD_PIXEL);
  assign fire     = is_pix ? (pend_q >= lim) : (pend_q != '0);
  assign slot_inc = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  // Ring slot of the reported position
  assign base_sl = is_pix ? slot_inc : slot_q;
  assign base_pn = SLOT_W'(is_pix ? pend_inc : pend_q);
  assign base    = (base_sl >= base_pn) ? base_sl - base_pn
                                        : base_sl + SLOT_W'(RING_DEPTH) - base_pn;

  assign border = (orow_q == '0) || (SIZE_W'(orow_q) >= hm1) ||
                  (ocol_q == '0) || (SIZE_W'(ocol_q) >= wm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      thresh_q <= THRESH_RESET;
      slot_q   <= '0;
      pend_q   <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
    end else begin
      if (cmd.accept) begin
        if (is_pix) begin
          slot_q <= slot_inc;
          pend_q <= fire ? pend_q : pend_inc;
        end else if (fire) begin
          pend_q <= pend_q - 1'b1;
        end
        if (fire) begin
          if (SIZE_W'(ocol_q) == wm1) begin
            ocol_q <= '0;
            orow_q <= (SIZE_W'(orow_q) == hm1) ? '0 : orow_q + 1'b1;
          end else begin
            ocol_q <= ocol_q + 1'b1;
          end
        end
      end
      // Size writes restart the frame
      if (cfg_write) begin
        case (cfg_index)
          CFG_WIDTH: begin
            width_q <= clamp_size(cfg_data[SIZE_W-1:0], SIZE_W'(MAX_WIDTH));
            pend_q  <= '0;
            ocol_q  <= '0;
            orow_q  <= '0;
          end
          CFG_HEIGHT: begin
            height_q <= clamp_size(cfg_data[SIZE_W-1:0], SIZE_W'(MAX_HEIGHT));
            pend_q   <= '0;
            ocol_q   <= '0;
            orow_q   <= '0;
          end
          CFG_THRESH: thresh_q <= cfg_data[RESP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Position under work, latched when an item fires
  logic [SLOT_W-1:0]  base_q;
  logic [COORD_W-1:0] cur_col_q, cur_row_q;
  logic cur_last_q, cur_border_q;
  logic refl_top_q, refl_bot_q, refl_left_q, refl_right_q;

  always_ff @(posedge clk) begin
    if (cmd.accept && fire) begin
      base_q       <= base;
      cur_col_q    <= ocol_q;
      cur_row_q    <= orow_q;
      cur_last_q   <= (SIZE_W'(ocol_q) == wm1) && (SIZE_W'(orow_q) == hm1);
      cur_border_q <= border;
      refl_top_q   <= (orow_q == COORD_W'(1));
      refl_bot_q   <= (SIZE_W'(orow_q) == hm1 - 1'b1);
      refl_left_q  <= (ocol_q == COORD_W'(1));
      refl_right_q <= (SIZE_W'(ocol_q) == wm1 - 1'b1);
    end
  end

  // Pixel writes
  assign ram_wr_en   = cmd.accept && is_pix;
  assign ram_wr_addr = slot_q;
  assign ram_wr_data = pixel;

  // Read address: base plus reflected row and column offsets, wrapped once
  logic signed [OFF_W-1:0] w_s, roff, coff, asum, awrap;

  assign w_s = OFF_W'(width_q);

  always_comb begin
    case (cmd.fetch_row)
      FIDX_W'(0): roff = refl_top_q ? '0 : -(w_s + w_s);
      FIDX_W'(1): roff = -w_s;
      FIDX_W'(3): roff = w_s;
      FIDX_W'(4): roff = refl_bot_q ? '0 : (w_s + w_s);
      default:    roff = '0;
    endcase
    case (cmd.fetch_col)
      FIDX_W'(0): coff = refl_left_q ? '0 : -OFF_W'(2);
      FIDX_W'(1): coff = -OFF_W'(1);
      FIDX_W'(3): coff = OFF_W'(1);
      FIDX_W'(4): coff = refl_right_q ? '0 : OFF_W'(2);
      default:    coff = '0;
    endcase
    asum = signed'(OFF_W'(base_q)) + roff + coff;
    if (asum < 0) begin
      awrap = asum + signed'(OFF_W'(RING_DEPTH));
    end else if (asum >= signed'(OFF_W'(RING_DEPTH))) begin
      awrap = asum - signed'(OFF_W'(RING_DEPTH));
    end else begin
      awrap = asum;
    end
  end

  assign ram_rd_en   = cmd.rd_en;
  assign ram_rd_addr = SLOT_W'(awrap);

  // 5x5 grid filled as a shift line, one pixel per read
  logic shift_q;
  logic [PIX_W-1:0] grid_q [GRID];

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_q <= 1'b0;
    end else begin
      shift_q <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_q) begin
      for (int i = 0; i < GRID - 1; i++) begin
        grid_q[i] <= grid_q[i + 1];
      end
      grid_q[GRID-1] <= ram_rd_data;
    end
  end

  // Nine gradient pairs over the grid
  logic signed [GRAD_W-1:0] dx_c [NGRAD];
  logic signed [GRAD_W-1:0] dy_c [NGRAD];
  logic signed [GRAD_W-1:0] gx_q [NGRAD];
  logic signed [GRAD_W-1:0] gy_q [NGRAD];

  always_comb begin
    for (int gi = 0; gi < SOBEL; gi++) begin
      for (int gj = 0; gj < SOBEL; gj++) begin
        dx_c[gi*SOBEL+gj] = sobel_d(
          grid_q[gi*WIN+gj+2],     grid_q[gi*WIN+gj],
          grid_q[(gi+1)*WIN+gj+2], grid_q[(gi+1)*WIN+gj],
          grid_q[(gi+2)*WIN+gj+2], grid_q[(gi+2)*WIN+gj]);
        dy_c[gi*SOBEL+gj] = sobel_d(
          grid_q[(gi+2)*WIN+gj],   grid_q[gi*WIN+gj],
          grid_q[(gi+2)*WIN+gj+1], grid_q[gi*WIN+gj+1],
          grid_q[(gi+2)*WIN+gj+2], grid_q[gi*WIN+gj+2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad_load) begin
      for (int k = 0; k < NGRAD; k++) begin
        gx_q[k] <= dx_c[k];
        gy_q[k] <= dy_c[k];
      end
    end else if (cmd.grad_shift) begin
      for (int k = 0; k < NGRAD - 1; k++) begin
        gx_q[k] <= gx_q[k + 1];
        gy_q[k] <= gy_q[k + 1];
      end
      gx_q[NGRAD-1] <= '0;
      gy_q[NGRAD-1] <= '0;
    end
  end

  // Shared multiplier, product registered with its destination
  logic [RESP_W-1:0]        sxx_q, syy_q;
  logic signed [ACC_W-1:0]  sxy_q, diff, ma, mb;
  logic signed [PROD_W-1:0] prod_q;
  mul_op_t                  pdst_q;
  logic [DISC_W-1:0]        disc_q;
  logic [ROOT_W-1:0]        root_q;
  logic [REM_W-1:0]         rem_q, rem_sh, trial;
  logic [RESP_W-1:0]        half_q;
  logic signed [ACC_W:0]    num;

  assign diff = signed'(ACC_W'(sxx_q) - ACC_W'(syy_q));

  always_comb begin
    case (cmd.mul_op)
      MUL_XX: begin ma = ACC_W'(gx_q[0]); mb = ACC_W'(gx_q[0]); end
      MUL_YY: begin ma = ACC_W'(gy_q[0]); mb = ACC_W'(gy_q[0]); end
      MUL_XY: begin ma = ACC_W'(gx_q[0]); mb = ACC_W'(gy_q[0]); end
      MUL_DD: begin ma = diff;            mb = diff;            end
      MUL_SS: begin ma = sxy_q;           mb = sxy_q;           end
      default: begin ma = '0;             mb = '0;              end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pdst_q <= MUL_NONE;
    end else begin
      pdst_q <= cmd.mul_op;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= ma * mb;
  end

  // Square root step: two bits of the discriminant per cycle
  assign rem_sh = {rem_q[REM_W-3:0], disc_q[DISC_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign num    = signed'((ACC_W+1)'(sxx_q) + (ACC_W+1)'(syy_q) - (ACC_W+1)'(root_q));

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      sxx_q  <= '0;
      syy_q  <= '0;
      sxy_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
    end else begin
      case (pdst_q)
        MUL_XX: sxx_q  <= sxx_q + RESP_W'(prod_q);
        MUL_YY: syy_q  <= syy_q + RESP_W'(prod_q);
        MUL_XY: sxy_q  <= sxy_q + ACC_W'(prod_q);
        MUL_DD: disc_q <= DISC_W'(prod_q);
        MUL_SS: disc_q <= disc_q + DISC_W'(prod_q <<< 2);
        default: ;
      endcase
      if (cmd.sqrt_step) begin
        disc_q <= disc_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
    end
    // Halved response, clamped at zero
    if (cmd.fin) begin
      half_q <= num[ACC_W] ? '0 : num[RESP_W:1];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      response      <= (!cur_border_q && (half_q > thresh_q)) ? half_q : '0;
      column        <= cur_col_q;
      row           <= cur_row_q;
      last_of_frame <= cur_last_q;
    end
  end

  assign sts.fire     = fire;
  assign sts.border   = border;
  assign sts.out_free = !out_valid || !out_stall;

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_q <= lim) else $error("pending count above the window lag");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_q < SLOT_W'(RING_DEPTH)) else $error("write slot outside the ring");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (SIZE_W'(ocol_q) < width_q) && (SIZE_W'(orow_q) < height_q))
    else $error("output position outside the frame");

endmodule

`default_nettype wire

// ----- rtl/mecr_ctrl.sv -----
// Controller: sequences fetch, gradients, products, square root and result.
// Depends on mecr_pkg.
`default_nettype none

module mecr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output mecr_pkg::dp_cmd_t cmd,
  input  mecr_pkg::dp_sts_t sts
);
  import mecr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_DRAIN,
    S_GRAD,
    S_MUL,
    S_DD,
    S_SS,
    S_WAIT,
    S_SQRT,
    S_FIN,
    S_DONE
  } state_t;

  state_t            state_q;
  logic [FIDX_W-1:0] frow_q, fcol_q;
  logic [GK_W-1:0]   gk_q;
  logic [1:0]        ph_q;
  logic [SQ_W-1:0]   sq_q;

  // Command decode
  always_comb begin
    cmd            = '0;
    cmd.mul_op     = MUL_NONE;
    cmd.accept     = (state_q == S_IDLE) && in_valid;
    cmd.fetch_row  = frow_q;
    cmd.fetch_col  = fcol_q;
    case (state_q)
      S_FETCH: cmd.rd_en = 1'b1;
      S_GRAD: begin
        cmd.grad_load = 1'b1;
        cmd.clear     = 1'b1;
      end
      S_MUL: begin
        case (ph_q)
          2'd0:    cmd.mul_op = MUL_XX;
          2'd1:    cmd.mul_op = MUL_YY;
          default: cmd.mul_op = MUL_XY;
        endcase
        cmd.grad_shift = (ph_q == 2'd2);
      end
      S_DD:   cmd.mul_op    = MUL_DD;
      S_SS:   cmd.mul_op    = MUL_SS;
      S_SQRT: cmd.sqrt_step = 1'b1;
      S_FIN:  cmd.fin       = 1'b1;
      S_DONE: cmd.load_out  = sts.out_free;
      default: ;
    endcase
  end

  assign in_stall = (state_q != S_IDLE);

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= S_IDLE;
      frow_q  <= '0;
      fcol_q  <= '0;
      gk_q    <= '0;
      ph_q    <= '0;
      sq_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          frow_q <= '0;
          fcol_q <= '0;
          if (in_valid && sts.fire) begin
            state_q <= sts.border ? S_DONE : S_FETCH;
          end
        end
        S_FETCH: begin
          if (fcol_q == FIDX_W'(WIN - 1)) begin
            fcol_q <= '0;
            frow_q <= frow_q + 1'b1;
            if (frow_q == FIDX_W'(WIN - 1)) begin
              state_q <= S_DRAIN;
            end
          end else begin
            fcol_q <= fcol_q + 1'b1;
          end
        end
        S_DRAIN: state_q <= S_GRAD;
        S_GRAD: begin
          gk_q    <= '0;
          ph_q    <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (ph_q == 2'd2) begin
            ph_q <= '0;
            gk_q <= gk_q + 1'b1;
            if (gk_q == GK_W'(NGRAD - 1)) begin
              state_q <= S_DD;
            end
          end else begin
            ph_q <= ph_q + 1'b1;
          end
        end
        S_DD:   state_q <= S_SS;
        S_SS:   state_q <= S_WAIT;
        S_WAIT: begin
          sq_q    <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          sq_q <= sq_q + 1'b1;
          if (sq_q == SQ_W'(ROOT_W - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: state_q <= S_DONE;
        S_DONE: begin
          if (sts.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free) else $error("result loaded over a held result");

  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.fire) |=> in_stall) else $error("firing item did not start work");

  a_sqrt_len: assert property (@(posedge clk) disable iff (rst)
    (state_q == S_FIN) |-> $past(state_q == S_SQRT) && ($past(sq_q) == SQ_W'(ROOT_W - 1)))
    else $error("square root ended early");

endmodule

`default_nettype wire

// ----- test/corner_checker.sv -----
// Checker for the minimum-eigenvalue corner response core: watches the
// pixel, result and register channels, predicts each result and compares.
// Depends on mecr_pkg.
`timescale 1ns / 100ps

module corner_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             command,
  input  logic [mecr_pkg::PIX_W-1:0]       pixel,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [mecr_pkg::RESP_W-1:0]      response,
  input  logic [mecr_pkg::COORD_W-1:0]     column,
  input  logic [mecr_pkg::COORD_W-1:0]     row,
  input  logic                             last_of_frame,
  input  logic                             cfg_write,
  input  logic [mecr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mecr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               outstanding
);
  import mecr_pkg::*;

  typedef struct packed {
    logic [RESP_W-1:0]  resp;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] line;
    logic               last;
  } corner_t;

  corner_t expected_corners[$];

  // Predictor state: pixel ring, raster counters and register copies
  byte unsigned      shade_ring [RING_DEPTH];
  int                write_slot;
  int                in_col;
  int                in_row;
  int                out_pos;
  int                backlog;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [RESP_W-1:0] thresh_reg;

  function automatic int clamp_dim(logic [SIZE_W-1:0] v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Mirror about the edge without repeating the edge pixel
  function automatic int mirror(int i, int n);
    if (i < 0) return -i;
    if (i >= n) return 2 * n - 2 - i;
    return i;
  endfunction

  function automatic logic [RESP_W-1:0] corner_strength(int base, int r, int c, int w, int h);
    longint sxx, syy, sxy, d, num;
    longint unsigned disc, root, bitv;
    int p [3][3];
    int dx, dy, off;
    if (r <= 0 || r >= h - 1 || c <= 0 || c >= w - 1) return '0;
    sxx = 0;
    syy = 0;
    sxy = 0;
    for (int gy = -1; gy <= 1; gy++) begin
      for (int gx = -1; gx <= 1; gx++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            off = (mirror(r + gy + i - 1, h) - r) * w + (mirror(c + gx + j - 1, w) - c);
            p[i][j] = shade_ring[(base + RING_DEPTH + off) % RING_DEPTH];
          end
        end
        dx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
        dy = (p[2][0] - p[0][0]) + 2 * (p[2][1] - p[0][1]) + (p[2][2] - p[0][2]);
        sxx += longint'(dx) * dx;
        syy += longint'(dy) * dy;
        sxy += longint'(dx) * dy;
      end
    end
    d = sxx - syy;
    disc = longint'(d * d) + 4 * longint'(sxy * sxy);
    // Floor square root, two bits per step
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > disc) bitv >>= 2;
    while (bitv != 0) begin
      if (disc >= root + bitv) begin
        disc -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    num = sxx + syy - longint'(root);
    if (num < 0) num = 0;
    num = num / 2;
    return (num > thresh_reg) ? num[RESP_W-1:0] : '0;
  endfunction

  task automatic restart_frame();
    in_col = 0;
    in_row = 0;
    out_pos = 0;
    backlog = 0;
  endtask

  // One accepted input item: update state, queue the result it causes
  task automatic take_item(logic cmd, logic [PIX_W-1:0] pix);
    int w, h, total, base;
    logic produce;
    corner_t exp_c;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    produce = 1'b0;
    if (cmd == CMD_PIXEL) begin
      shade_ring[write_slot] = pix;
      write_slot = (write_slot + 1) % RING_DEPTH;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      backlog++;
      produce = (backlog > 2 * w + 2);
    end else begin
      produce = (backlog != 0);
    end
    if (produce) begin
      base = (write_slot + RING_DEPTH - backlog) % RING_DEPTH;
      exp_c.resp = corner_strength(base, out_pos / w, out_pos % w, w, h);
      exp_c.col = COORD_W'(out_pos % w);
      exp_c.line = COORD_W'(out_pos / w);
      exp_c.last = (out_pos == total - 1);
      expected_corners.insert(expected_corners.size(), exp_c);
      out_pos++;
      if (out_pos >= total) out_pos = 0;
      backlog--;
    end
  endtask

  task automatic report(string field, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Channel monitor
  always @(posedge clk) begin
    corner_t exp_c;
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) shade_ring[i] = 0;
      write_slot = 0;
      restart_frame();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      thresh_reg = THRESH_RESET;
      expected_corners.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WIDTH: begin
            width_reg = cfg_data[SIZE_W-1:0];
            restart_frame();
          end
          CFG_HEIGHT: begin
            height_reg = cfg_data[SIZE_W-1:0];
            restart_frame();
          end
          CFG_THRESH: thresh_reg = cfg_data[RESP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_item(command, pixel);
      if (out_valid && !out_stall) begin
        if (expected_corners.size() == 0) begin
          $display("%0t: result transfer with nothing expected (col %0d row %0d)",
                   $realtime, column, row);
          errors++;
        end else begin
          exp_c = expected_corners.pop_front();
          if (response !== exp_c.resp) report("response", response, exp_c.resp);
          if (column !== exp_c.col) report("column", column, exp_c.col);
          if (row !== exp_c.line) report("row", row, exp_c.line);
          if (last_of_frame !== exp_c.last) report("last_of_frame", last_of_frame, exp_c.last);
        end
      end
    end
    outstanding <= expected_corners.size();
  end

endmodule

// ----- test/testbench.sv -----
// Top of the corner response testbench: clock, reset, pixel and register
// stimulus, output stalls, watchdog and verdict. Uses corner_checker and mecr_pkg.
`timescale 1ns / 100ps

module testbench;
  import mecr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 200;
  localparam int SMALL_ITEMS   = 1000;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  command;
  logic [PIX_W-1:0]      pixel;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RESP_W-1:0]     response;
  logic [COORD_W-1:0]    column;
  logic [COORD_W-1:0]    row;
  logic                  last_of_frame;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    outstanding;

  int burst_left;
  int small_items;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  min_eigen_corner_response_core uut (.*);

  corner_checker chk (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Output stalls: phases of none, light, half and heavy stalling
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input transfer; bursts separated by random gaps
  task automatic send_item(logic cmd, logic [PIX_W-1:0] pix);
    logic stalled;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    pixel <= pix;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // Sender holds off until every expected result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int clamp_dim(int v);
    return (v < 3) ? 3 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
  endfunction

  // Pixels of a frame (or its first count pixels) in one of several textures
  task automatic send_frame(int w, int h, int count);
    int style, blk, lo, hi, kx, ky, sent;
    logic [PIX_W-1:0] pix;
    style = $urandom_range(0, 3);
    blk = $urandom_range(1, 4);
    lo = $urandom_range(0, 255);
    hi = $urandom_range(0, 255);
    kx = $urandom_range(0, 40);
    ky = $urandom_range(0, 40);
    sent = 0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (sent < count) begin
          case (style)
            0: pix = $urandom_range(0, 255);
            1: pix = (((x / blk) + (y / blk)) % 2) ? hi[7:0] : lo[7:0];
            2: pix = ((x * kx + y * ky) > 255) ? 8'hFF : PIX_W'(x * kx + y * ky);
            default: pix = (lo > 251) ? 8'hFF : PIX_W'(lo + $urandom_range(0, 3));
          endcase
          send_item(CMD_PIXEL, pix);
          sent++;
        end
      end
    end
  endtask

  task automatic send_flushes(int n);
    repeat (n) send_item(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
  endtask

  initial begin
    int raw_w, raw_h, w, h, frames, phase;
    logic [RESP_W-1:0] thresh;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_PIXEL;
    pixel = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    burst_left = 0;
    small_items = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: flush with nothing pending, then two 3x3 frames back to back
    send_item(CMD_FLUSH, 8'hA5);
    drain();
    write_reg(CFG_WIDTH, 24'd3);
    write_reg(CFG_HEIGHT, 24'd3);
    write_reg(CFG_THRESH, 24'd0);
    write_reg(CFG_SPARE, 24'hFFFFFF);
    for (int k = 0; k < 9; k++) send_item(CMD_PIXEL, k[0] ? 8'hFF : 8'h00);
    for (int k = 0; k < 9; k++) send_item(CMD_PIXEL, (k == 4) ? 8'h00 : 8'hFF);
    send_flushes(9);
    drain();

    // Random phases, each with its own register setting
    phase = 0;
    while (small_items < SMALL_ITEMS || phase < 4) begin
      raw_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      raw_h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      if (phase == 2) begin
        raw_h = 2047;
      end
      case ($urandom_range(0, 5))
        0: thresh = '0;
        1: thresh = THRESH_RESET;
        2: thresh = $urandom_range(0, 2000);
        3: thresh = 24'd9363600;
        4: thresh = 24'hFFFFFF;
        default: thresh = $urandom_range(0, 200000);
      endcase
      write_reg(CFG_WIDTH, CFG_DATA_W'(raw_w));
      write_reg(CFG_HEIGHT, CFG_DATA_W'(raw_h));
      write_reg(CFG_THRESH, thresh);
      w = clamp_dim(raw_w);
      h = clamp_dim(raw_h);
      if (phase == 2) begin
        // Tall frame is cut short: the size write ends it
        send_frame(w, h, 12 * w);
        small_items += 12 * w;
        drain();
        write_reg(CFG_WIDTH, 24'd5);
      end else if ($urandom_range(0, 5) == 0) begin
        // Abandoned frame: restarted by the next size write
        send_frame(w, h, $urandom_range(1, w * h - 1));
        small_items += w * h;
      end else begin
        frames = $urandom_range(1, 3);
        repeat (frames) send_frame(w, h, w * h);
        send_flushes(2 * w + 2 + $urandom_range(0, 2));
        small_items += frames * w * h + 2 * w + 2;
      end
      drain();
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
